// ===== src/ordarr_pkg.sv =====
// Shared constants and types for the ordered array block.
`timescale 1ns / 1ps

package ordarr_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int WORD_W        = 32;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== src/ordered_array_insert_delete_search.sv =====
// Top level of the ordered array: sequencer, entry store and checks.
`timescale 1ns / 1ps

// Ordered array of signed 32-bit words with a fill count.
// A transaction is taken at a clock edge where start is high and busy is low.
// req_operation selects insert at req_position, delete at req_position, or a
// linear search for req_value. Every transaction gives one response, shown
// for a single cycle with rsp_strobe high; the receiver must take it then.
// A rejected transaction (full, bad index, unused code, empty search) is answered
// from idle without touching the store. An insert first moves the entries from
// its position upward one place (an append moves none), a delete moves the entries
// above its position one place down, and a search stops at the first match.
// The walk moves or compares one entry a cycle through the store's read port;
// busy is high for the whole walk and one transaction is handled at a time.
// A new transaction may be taken in the cycle its predecessor's response is
// shown. Reset empties the array at once (the count goes to zero); entries
// are not cleared and need no sweep.

module ordered_array_insert_delete_search #(
   parameter int DEPTH = ordarr_pkg::DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_operation,
   input  logic [5:0]                             req_position,
   input  logic signed [ordarr_pkg::WORD_W-1:0]   req_value,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [4:0]                             rsp_found_position,
   output logic [5:0]                             rsp_fill_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   ordarr_pkg::mem_ctl_type              mem_ctl;
   logic [AW-1:0]                        mem_wr_addr;
   logic signed [ordarr_pkg::WORD_W-1:0] mem_wr_data;
   logic [AW-1:0]                        mem_rd_addr;
   logic signed [ordarr_pkg::WORD_W-1:0] mem_rd_data;

   ordarr_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_count     (rsp_fill_count),
      .mem_ctl            (mem_ctl),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

   ordarr_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // an accepted transaction either answers at once or holds busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted transaction neither answered nor in progress");

   // a refused insert reports the array as holding DEPTH entries
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ordarr_pkg::ST_FULL) |-> (rsp_fill_count == 6'(DEPTH)))
      else $error("full status with a count below depth");

   // a failed transaction leaves the count alone
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ordarr_pkg::ST_OK) |-> $stable(rsp_fill_count))
      else $error("count changed on a failed transaction");

   // the found position is zero on a failed transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ordarr_pkg::ST_OK) |-> (rsp_found_position == 5'd0))
      else $error("found position set on a failed transaction");

endmodule

// ===== src/ordarr_mem.sv =====
// Entry store: one write port and one read port, registered read data.
`timescale 1ns / 1ps

module ordarr_mem #(
   parameter int DEPTH = ordarr_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                                   clock,
   input  ordarr_pkg::mem_ctl_type                ctl,
   input  logic [AW-1:0]                          wr_addr,
   input  logic signed [ordarr_pkg::WORD_W-1:0]   wr_data,
   input  logic [AW-1:0]                          rd_addr,
   output logic signed [ordarr_pkg::WORD_W-1:0]   rd_data
);

   logic signed [ordarr_pkg::WORD_W-1:0] store [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data <= store[rd_addr];
      end
   end

endmodule

// ===== src/ordarr_ctrl.sv =====
// Sequencer: decodes a transaction, walks the store to shift or scan, builds the response.
`timescale 1ns / 1ps

module ordarr_ctrl #(
   parameter int DEPTH = ordarr_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_operation,
   input  logic [5:0]                             req_position,
   input  logic signed [ordarr_pkg::WORD_W-1:0]   req_value,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [4:0]                             rsp_found_position,
   output logic [5:0]                             rsp_fill_count,
   output ordarr_pkg::mem_ctl_type                mem_ctl,
   output logic [AW-1:0]                          mem_wr_addr,
   output logic signed [ordarr_pkg::WORD_W-1:0]   mem_wr_data,
   output logic [AW-1:0]                          mem_rd_addr,
   input  logic signed [ordarr_pkg::WORD_W-1:0]   mem_rd_data
);

   localparam int XW = (CW > 6) ? CW : 6;

   typedef enum logic [2:0] {
      IDLE, INS_RD, INS_WR, INS_PUT, DEL_RD, DEL_WR, SRCH, SRCH_END
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [ordarr_pkg::WORD_W-1:0] val_ff, val_in;
   logic move_ff, move_in;
   logic chk_ff, chk_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [4:0] rsp_found_ff, rsp_found_in;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic [AW-1:0] last_idx;
   logic          match;

   assign pos_x    = XW'(req_position);
   assign cnt_x    = XW'(count_ff);
   assign last_idx = AW'(count_ff - CW'(1));
   assign match    = chk_ff && (mem_rd_data == val_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      wr_addr_in    = wr_addr_ff;
      chk_idx_in    = chk_idx_ff;
      count_in      = count_ff;
      val_in        = val_ff;
      move_in       = 1'b0;
      chk_in        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      mem_ctl       = '0;
      mem_rd_addr   = idx_ff;
      mem_wr_addr   = wr_addr_ff;
      mem_wr_data   = mem_rd_data;

      case (state_ff)
         IDLE: begin
            if (start) begin
               pos_in       = AW'(req_position);
               val_in       = req_value;
               rsp_found_in = 5'd0;
               case (req_operation)
                  ordarr_pkg::OP_INSERT: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ordarr_pkg::ST_FULL;
                     end else if (pos_x > cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ordarr_pkg::ST_BAD_INDEX;
                     end else if (pos_x == cnt_x) begin
                        state_in = INS_PUT;
                     end else begin
                        idx_in   = last_idx;
                        state_in = INS_RD;
                     end
                  end
                  ordarr_pkg::OP_DELETE: begin
                     if (pos_x >= cnt_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ordarr_pkg::ST_BAD_INDEX;
                     end else if (pos_x + XW'(1) == cnt_x) begin
                        state_in = DEL_WR;
                     end else begin
                        idx_in   = AW'(req_position) + AW'(1);
                        state_in = DEL_RD;
                     end
                  end
                  ordarr_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ordarr_pkg::ST_NOT_FOUND;
                     end else begin
                        idx_in   = '0;
                        state_in = SRCH;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ordarr_pkg::ST_BAD_INDEX;
                  end
               endcase
            end
         end

         // walk down from the top entry, each word lands one place higher
         INS_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.wr_en = move_ff;
            move_in       = 1'b1;
            wr_addr_in    = idx_ff + AW'(1);
            if (idx_ff == pos_ff) begin
               state_in = INS_WR;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end

         INS_WR: begin
            mem_ctl.wr_en = move_ff;
            state_in      = INS_PUT;
         end

         INS_PUT: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_addr   = pos_ff;
            mem_wr_data   = val_ff;
            count_in      = count_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ordarr_pkg::ST_OK;
            state_in      = IDLE;
         end

         // walk up from above the hole, each word lands one place lower
         DEL_RD: begin
            mem_ctl.rd_en = 1'b1;
            mem_ctl.wr_en = move_ff;
            move_in       = 1'b1;
            wr_addr_in    = idx_ff - AW'(1);
            if (idx_ff == last_idx) begin
               state_in = DEL_WR;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end

         DEL_WR: begin
            mem_ctl.wr_en = move_ff;
            count_in      = count_ff - CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ordarr_pkg::ST_OK;
            state_in      = IDLE;
         end

         // read one entry a cycle, compare the word fetched the cycle before
         SRCH: begin
            if (match) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ordarr_pkg::ST_OK;
               rsp_found_in  = 5'(chk_idx_ff);
               state_in      = IDLE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               chk_in        = 1'b1;
               chk_idx_in    = idx_ff;
               if (idx_ff == last_idx) begin
                  state_in = SRCH_END;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         SRCH_END: begin
            rsp_strobe_in = 1'b1;
            state_in      = IDLE;
            if (match) begin
               rsp_status_in = ordarr_pkg::ST_OK;
               rsp_found_in  = 5'(chk_idx_ff);
            end else begin
               rsp_status_in = ordarr_pkg::ST_NOT_FOUND;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         move_ff       <= 1'b0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         move_ff       <= move_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         wr_addr_ff    <= wr_addr_in;
         chk_idx_ff    <= chk_idx_in;
         val_ff        <= val_in;
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
      end
   end

   assign busy               = (state_ff != IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_fill_count     = 6'(count_ff);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the ordered array insert, delete and search block.
`timescale 1ns / 1ps

module tb_top;
   import ordarr_pkg::*;

   localparam int          ARRAY_DEPTH = DEPTH_DEFAULT;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam int          DRAIN_CYCLES = ARRAY_DEPTH + 8;
   localparam int          RANDOM_ITEMS = 1400;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] found_position;
      logic [5:0] fill_count;
   } array_result_type;

   // Shadow copy of the array; predicts each response and checks it on arrival.
   class ordered_array_tracker;
      logic [WORD_W-1:0] entries [ARRAY_DEPTH];
      int unsigned       fill;
      array_result_type  pending_results [$];
      int unsigned       mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [1:0] op, logic [5:0] pos, logic [WORD_W-1:0] val);
         array_result_type r;
         int unsigned      i;
         r.status = ST_OK;
         r.found_position = '0;
         case (op)
            OP_INSERT: begin
               if (fill >= ARRAY_DEPTH) begin
                  r.status = ST_FULL;
               end else if (pos > fill) begin
                  r.status = ST_BAD_INDEX;
               end else begin
                  for (i = fill; i > pos; i--) entries[i] = entries[i-1];
                  entries[pos] = val;
                  fill++;
               end
            end
            OP_DELETE: begin
               if (pos >= fill) begin
                  r.status = ST_BAD_INDEX;
               end else begin
                  for (i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
                  fill--;
               end
            end
            OP_SEARCH: begin
               r.status = ST_NOT_FOUND;
               // keep the lowest matching position
               for (i = 0; i < fill; i++) begin
                  if (r.status == ST_NOT_FOUND && entries[i] == val) begin
                     r.status = ST_OK;
                     r.found_position = i[4:0];
                  end
               end
            end
            default: r.status = ST_BAD_INDEX;
         endcase
         r.fill_count = fill[5:0];
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_response(logic [1:0] status, logic [4:0] found_pos, logic [5:0] fill_cnt);
         array_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response with no transaction outstanding", 32'(status), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (status !== want.status)
               report_mismatch("status", 32'(status), 32'(want.status));
            if (found_pos !== want.found_position)
               report_mismatch("found_position", 32'(found_pos), 32'(want.found_position));
            if (fill_cnt !== want.fill_count)
               report_mismatch("fill_count", 32'(fill_cnt), 32'(want.fill_count));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_operation = OP_INSERT;
   logic [5:0]               req_position = '0;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_strobe;
   logic [1:0]               rsp_status;
   logic [4:0]               rsp_found_position;
   logic [5:0]               rsp_fill_count;

   ordered_array_tracker tracker;
   bit                   no_idle = 1'b0;

   ordered_array_insert_delete_search #(
      .DEPTH(ARRAY_DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_count     (rsp_fill_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Present one transaction at a falling edge and hold it until it is taken.
   task automatic send_request(logic [1:0] op, logic [5:0] pos, logic [WORD_W-1:0] val);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_position  <= pos;
      req_value     <= val;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.note_request(op, pos, val);
   endtask

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(int unsigned n);
      bit          growing;
      int unsigned k;
      int unsigned roll;
      logic [1:0]  op;
      logic [5:0]  pos;
      logic [WORD_W-1:0] val;
      growing = 1'b1;
      for (k = 0; k < n; k++) begin
         if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         // drift the fill level between empty and full
         if (tracker.fill == ARRAY_DEPTH && $urandom_range(0, 2) == 0) growing = 1'b0;
         if (tracker.fill == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
         if ($urandom_range(0, 49) == 0) growing = !growing;
         roll = $urandom_range(0, 99);
         if (roll < 3) op = OP_UNUSED;
         else if (roll < 30) op = OP_SEARCH;
         else if ($urandom_range(0, 3) != 0) op = growing ? OP_INSERT : OP_DELETE;
         else op = growing ? OP_DELETE : OP_INSERT;
         val = pick_value();
         if ($urandom_range(0, 9) == 0)
            pos = 6'($urandom_range(0, 63));
         else if (op == OP_INSERT)
            pos = 6'($urandom_range(0, tracker.fill));
         else
            pos = (tracker.fill == 0) ? 6'd0 : 6'($urandom_range(0, tracker.fill - 1));
         if (op == OP_SEARCH && tracker.fill > 0 && $urandom_range(0, 9) < 6)
            val = tracker.entries[$urandom_range(0, tracker.fill - 1)];
         send_request(op, pos, val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            tracker.check_response(rsp_status, rsp_found_position, rsp_fill_count);
         else if (rsp_strobe !== 1'b0)
            tracker.report_mismatch("rsp_strobe unknown", 32'(rsp_strobe), 32'd0);
      end
   end

   initial begin
      tracker = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: empty array, bounds, append, middle insert, duplicates, extremes
      send_request(OP_SEARCH, 6'd0, 32'h0);
      send_request(OP_DELETE, 6'd0, 32'h0);
      send_request(OP_INSERT, 6'd1, 32'h1);
      send_request(OP_INSERT, 6'd63, 32'h7fff_ffff);
      send_request(OP_INSERT, 6'd0, 32'h7fff_ffff);
      send_request(OP_INSERT, 6'd1, 32'h8000_0000);
      send_request(OP_INSERT, 6'd1, 32'h5);
      send_request(OP_INSERT, 6'd0, 32'h5);
      send_request(OP_SEARCH, 6'd0, 32'h5);
      send_request(OP_SEARCH, 6'd63, 32'h8000_0000);
      send_request(OP_SEARCH, 6'd0, 32'hffff_ffff);
      send_request(OP_UNUSED, 6'd0, 32'h0);
      send_request(OP_UNUSED, 6'd63, 32'hffff_ffff);
      send_request(OP_DELETE, 6'd4, 32'h0);
      send_request(OP_DELETE, 6'd63, 32'h0);
      send_request(OP_DELETE, 6'd0, 32'h0);
      send_request(OP_SEARCH, 6'd0, 32'h5);
      send_request(OP_DELETE, 6'd2, 32'h0);
      send_request(OP_INSERT, 6'd3, 32'h0);
      send_request(OP_DELETE, 6'd0, 32'h0);
      send_request(OP_DELETE, 6'd0, 32'h0);
      send_request(OP_SEARCH, 6'd0, 32'h7fff_ffff);

      run_random(RANDOM_ITEMS);

      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TIMEOUT: transactions still outstanding");
      $display("Test completed with failures");
      $finish;
   end

endmodule
